// File: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_ELEM_WIDTH = 32;
   localparam int INDEX_W        = 8;
   localparam int OP_W           = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_HEAD  = 3'd0,
      OP_PUSH_TAIL  = 3'd1,
      OP_POP_HEAD   = 3'd2,
      OP_POP_TAIL   = 3'd3,
      OP_READ_HEAD  = 3'd4,
      OP_READ_TAIL  = 3'd5,
      OP_READ_INDEX = 3'd6
   } bdq_op_type;

   typedef struct packed {
      logic ok;   // request took effect / read valid
      logic rd;   // result carries memory read data
   } bdq_flags_type;

endpackage

`default_nettype wire

// File: sv/bounded_deque_with_index_read_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_unit
// Bounded ring-buffer deque: push/pop at either end, read head, tail or index.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | tuser: op[2:0]; tdata: elem_index[7:0], elem_data
//  rsp     | out | tdata: read_data, accepted, count
//
//  One request per cycle while rsp is not stalled; the result is registered
//  by the element RAM read in the read stage, then by the output register.
//  Reset clears head, count and valid flags only; element RAM holds no reset.
//  A stalled rsp holds in the output register while one more request is
//  taken into the read stage; req_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_index_read_unit
   import bdq_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
   localparam int PTR_W     = $clog2(CAPACITY),
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int REQ_TDATA_W = ((INDEX_W + ELEM_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((ELEM_WIDTH + 1 + CNT_W + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // elem_index, elem_data
   input  wire logic [OP_W-1:0]        req_tuser,  // req_type
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata   // read_data, accepted, count
);

   logic                  accept;
   logic                  wr_en, rd_en;
   logic [PTR_W-1:0]      wr_addr, rd_addr;
   logic [ELEM_WIDTH-1:0] wr_data, ram_data;
   bdq_flags_type         flags;
   logic [CNT_W-1:0]      count_next;
   logic [ELEM_WIDTH-1:0] read_data;
   logic                  accepted;
   logic [CNT_W-1:0]      count;

   assign accept = req_tvalid & req_tready;

   bdq_ctrl #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (bdq_op_type'(req_tuser)),
      .elem_index (req_tdata[INDEX_W-1:0]),
      .elem_data  (req_tdata[INDEX_W +: ELEM_WIDTH]),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .flags      (flags),
      .count_next (count_next)
   );

   bdq_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   bdq_rsp #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CNT_W)
   ) u_rsp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .flags      (flags),
      .count_next (count_next),
      .ram_data   (ram_data),
      .ready      (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .read_data  (read_data),
      .accepted   (accepted),
      .count      (count)
   );

   assign rsp_tdata = RSP_TDATA_W'({count, accepted, read_data});

endmodule

`default_nettype wire

// File: sv/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decode, ring slot arithmetic and head/count state.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
   localparam int PTR_W     = $clog2(CAPACITY),
   localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire bdq_op_type            op,
   input  wire logic [INDEX_W-1:0]    elem_index,
   input  wire logic [ELEM_WIDTH-1:0] elem_data,
   output logic                       wr_en,
   output logic [PTR_W-1:0]           wr_addr,
   output logic [ELEM_WIDTH-1:0]      wr_data,
   output logic                       rd_en,
   output logic [PTR_W-1:0]           rd_addr,
   output bdq_flags_type              flags,
   output logic [CNT_W-1:0]           count_next
);

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [PTR_W:0]   CAP_SUM = (PTR_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             not_full, not_empty, idx_ok;
   logic             ok, rd, wen;
   logic [PTR_W-1:0] head_dec, head_inc, tail_slot, last_slot, index_slot;

   // head + off modulo CAPACITY, both operands below CAPACITY
   function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   assign not_full   = (count_ff != CAP_CNT);
   assign not_empty  = (count_ff != '0);
   assign idx_ok     = (CMP_W'(elem_index) < CMP_W'(count_ff));
   assign head_dec   = (head_ff == '0) ? LAST_SLOT : head_ff - PTR_W'(1);
   assign head_inc   = slot_add(head_ff, PTR_W'(1));
   assign tail_slot  = slot_add(head_ff, PTR_W'(count_ff));
   assign last_slot  = slot_add(head_ff, PTR_W'(count_ff - CNT_W'(1)));
   assign index_slot = slot_add(head_ff, PTR_W'(elem_index));

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ok       = 1'b0;
      rd       = 1'b0;
      wen      = 1'b0;
      wr_addr  = tail_slot;
      rd_addr  = head_ff;
      unique case (op)
         OP_PUSH_HEAD: begin
            wr_addr = head_dec;
            if (not_full) begin
               ok       = 1'b1;
               wen      = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_TAIL: begin
            if (not_full) begin
               ok       = 1'b1;
               wen      = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_HEAD: begin
            if (not_empty) begin
               ok       = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_POP_TAIL: begin
            if (not_empty) begin
               ok       = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ_HEAD: begin
            ok = not_empty;
            rd = not_empty;
         end
         OP_READ_TAIL: begin
            rd_addr = last_slot;
            ok      = not_empty;
            rd      = not_empty;
         end
         OP_READ_INDEX: begin
            rd_addr = index_slot;
            ok      = idx_ok;
            rd      = idx_ok;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign wr_en      = accept & wen;
   assign wr_data    = elem_data;
   assign rd_en      = accept;
   assign flags.ok   = ok;
   assign flags.rd   = rd;
   assign count_next = count_in;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count exceeds capacity");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !ok |=> $stable(count_ff) && $stable(head_ff))
      else $error("rejected request changed state");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow count");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      !(rd && wen))
      else $error("read and write in one request");
`endif

endmodule

`default_nettype wire

// File: sv/bdq_rsp.sv
// ----------------------------------------------------------------------------
// bdq_rsp
// Result stage waiting on RAM read data, followed by the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_rsp
   import bdq_pkg::*;
#(
   parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
   parameter int CNT_W      = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire bdq_flags_type         flags,
   input  wire logic [CNT_W-1:0]      count_next,
   input  wire logic [ELEM_WIDTH-1:0] ram_data,
   output logic                       ready,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [ELEM_WIDTH-1:0]      read_data,
   output logic                       accepted,
   output logic [CNT_W-1:0]           count
);

   logic                  s1_valid_ff;
   bdq_flags_type         s1_flags_ff;
   logic [CNT_W-1:0]      s1_count_ff;
   logic                  out_valid_ff;
   logic [ELEM_WIDTH-1:0] out_data_ff, out_data_in;
   logic                  out_ok_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic                  s1_move;

   assign s1_move     = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign ready       = ~s1_valid_ff | s1_move;
   assign out_data_in = s1_flags_ff.rd ? ram_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
         s1_count_ff <= count_next;
      end
      if (s1_move) begin
         out_data_ff  <= out_data_in;
         out_ok_ff    <= s1_flags_ff.ok;
         out_count_ff <= s1_count_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign read_data  = out_data_ff;
   assign accepted   = out_ok_ff;
   assign count      = out_count_ff;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque with indexed read. A directed
// table covers the empty list, the pointer wrap and bad indexes. Random
// fill and drain passes then take the list to full and back to empty.
// Each response is checked against the row's typed result or the in-bench predictor.
// ----------------------------------------------------------------------------

module testbench;
   import bdq_pkg::*;

   localparam int          DEPTH        = DEF_CAPACITY;
   localparam logic [2:0]  OP_UNUSED    = 3'd7;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          QUIET_LEVEL  = 64;

   typedef struct packed {
      logic [31:0] read_data;
      logic        accepted;
      logic [8:0]  count;
   } deque_result_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  idx;
      logic [31:0] data;
      bit          typed;
      logic [31:0] rd;
      logic        ok;
      logic [8:0]  cnt;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // elem_index[7:0], elem_data[39:8]
   logic [2:0]  req_tuser;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // read_data[31:0], accepted[32], count[41:33]

   // predictor state
   logic [31:0] deque_words [DEPTH];
   logic [7:0]  deque_head;
   logic [8:0]  deque_level;

   deque_result_type pending_results[$];
   int  mismatch_count;
   int  results_checked;
   int  rejected_count;
   int  peak_level;
   int  idle_cycles;
   bit  quiet;
   bit  hold_rsp;

   directed_row_type directed_rows [25] = '{
      '{OP_POP_HEAD,   8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_POP_TAIL,   8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_READ_HEAD,  8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_READ_TAIL,  8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_READ_INDEX, 8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_READ_INDEX, 8'd255, 32'hffffffff, 1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_UNUSED,     8'd0,   32'h0,        1'b1, 32'h0,        1'b0, 9'd0},
      '{OP_PUSH_HEAD,  8'd0,   32'hffffffff, 1'b1, 32'h0,        1'b1, 9'd1},
      '{OP_PUSH_TAIL,  8'd255, 32'h00000000, 1'b1, 32'h0,        1'b1, 9'd2},
      '{OP_PUSH_HEAD,  8'd0,   32'ha5a5a5a5, 1'b1, 32'h0,        1'b1, 9'd3},
      '{OP_PUSH_TAIL,  8'd0,   32'h5a5a5a5a, 1'b1, 32'h0,        1'b1, 9'd4},
      '{OP_READ_HEAD,  8'd0,   32'h0,        1'b1, 32'ha5a5a5a5, 1'b1, 9'd4},
      '{OP_READ_TAIL,  8'd0,   32'h0,        1'b1, 32'h5a5a5a5a, 1'b1, 9'd4},
      '{OP_READ_INDEX, 8'd1,   32'h0,        1'b1, 32'hffffffff, 1'b1, 9'd4},
      '{OP_READ_INDEX, 8'd2,   32'h0,        1'b0, 32'h0,        1'b0, 9'd0},
      '{OP_READ_INDEX, 8'd4,   32'h0,        1'b1, 32'h0,        1'b0, 9'd4},
      '{OP_READ_INDEX, 8'd255, 32'h0,        1'b1, 32'h0,        1'b0, 9'd4},
      '{OP_UNUSED,     8'd255, 32'hffffffff, 1'b1, 32'h0,        1'b0, 9'd4},
      '{OP_POP_HEAD,   8'd0,   32'h0,        1'b1, 32'h0,        1'b1, 9'd3},
      '{OP_READ_HEAD,  8'd0,   32'h0,        1'b1, 32'hffffffff, 1'b1, 9'd3},
      '{OP_POP_TAIL,   8'd0,   32'h0,        1'b1, 32'h0,        1'b1, 9'd2},
      '{OP_READ_TAIL,  8'd0,   32'h0,        1'b0, 32'h0,        1'b0, 9'd0},
      '{OP_POP_TAIL,   8'd0,   32'h0,        1'b1, 32'h0,        1'b1, 9'd1},
      '{OP_POP_HEAD,   8'd0,   32'h0,        1'b1, 32'h0,        1'b1, 9'd0},
      '{OP_PUSH_TAIL,  8'd0,   32'h12345678, 1'b0, 32'h0,        1'b0, 9'd0}
   };

   bounded_deque_with_index_read_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic deque_result_type deque_apply(input logic [2:0] op, input logic [7:0] idx,
                                                    input logic [31:0] data);
      deque_result_type res;
      res = '0;
      case (op)
         OP_PUSH_HEAD: begin
            if (deque_level < DEPTH) begin
               deque_head = deque_head - 8'd1;
               deque_words[deque_head] = data;
               deque_level = deque_level + 9'd1;
               res.accepted = 1'b1;
            end
         end
         OP_PUSH_TAIL: begin
            if (deque_level < DEPTH) begin
               deque_words[8'(deque_head + deque_level)] = data;
               deque_level = deque_level + 9'd1;
               res.accepted = 1'b1;
            end
         end
         OP_POP_HEAD: begin
            if (deque_level != 0) begin
               deque_head = deque_head + 8'd1;
               deque_level = deque_level - 9'd1;
               res.accepted = 1'b1;
            end
         end
         OP_POP_TAIL: begin
            if (deque_level != 0) begin
               deque_level = deque_level - 9'd1;
               res.accepted = 1'b1;
            end
         end
         OP_READ_HEAD: begin
            if (deque_level != 0) begin
               res.read_data = deque_words[deque_head];
               res.accepted = 1'b1;
            end
         end
         OP_READ_TAIL: begin
            if (deque_level != 0) begin
               res.read_data = deque_words[8'(deque_head + deque_level - 9'd1)];
               res.accepted = 1'b1;
            end
         end
         OP_READ_INDEX: begin
            if ({1'b0, idx} < deque_level) begin
               res.read_data = deque_words[8'(deque_head + idx)];
               res.accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.count = deque_level;
      return res;
   endfunction

   // drive one request from a falling edge; returns at the falling edge after acceptance
   task automatic drive_request(input logic [2:0] op, input logic [7:0] idx,
                                input logic [31:0] data, input bit use_typed,
                                input deque_result_type typed);
      deque_result_type predicted;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {data, idx};
      do @(posedge clock); while (!req_tready);
      predicted = deque_apply(op, idx, data);
      pending_results.push_back(use_typed ? typed : predicted);
      if (!predicted.accepted) rejected_count++;
      if (int'(deque_level) > peak_level) peak_level = int'(deque_level);
      @(negedge clock);
   endtask

   task automatic random_request(input bit filling);
      int          pick;
      logic [2:0]  op;
      logic [7:0]  idx;
      pick = $urandom_range(0, 99);
      idx  = 8'($urandom_range(0, 255));
      if (pick < 47) op = filling ? OP_PUSH_HEAD : OP_POP_HEAD;
      else if (pick < 94) op = filling ? OP_PUSH_TAIL : OP_POP_TAIL;
      else if (pick < 95) op = OP_READ_HEAD;
      else if (pick < 96) op = OP_READ_TAIL;
      else if (pick < 99) op = OP_READ_INDEX;
      else op = OP_UNUSED;
      if (op == OP_READ_INDEX && deque_level != 0 && $urandom_range(0, 4) != 0)
         idx = 8'($urandom_range(0, int'(deque_level) - 1));
      drive_request(op, idx, $urandom, 1'b0, '0);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_tdata[31:0] !== want.read_data) begin
               $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                        rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[32] !== want.accepted) begin
               $display("%0t: accepted expected %b, got %b", $time, want.accepted,
                        rsp_tdata[32]);
               mismatch_count++;
            end
            if (rsp_tdata[41:33] !== want.count) begin
               $display("%0t: count expected %0d, got %0d", $time, want.count,
                        rsp_tdata[41:33]);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      deque_result_type typed;
      int               n;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      deque_head     = '0;
      deque_level    = '0;
      mismatch_count = 0;
      results_checked = 0;
      rejected_count = 0;
      peak_level     = 0;
      idle_cycles    = 0;
      quiet          = 1'b0;
      hold_rsp       = 1'b0;
      foreach (deque_words[k]) deque_words[k] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed = '{directed_rows[i].rd, directed_rows[i].ok, directed_rows[i].cnt};
         drive_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
                       directed_rows[i].typed, typed);
      end

      // fill to capacity; the response side holds off early so the input stalls
      n = 0;
      while (deque_level < DEPTH) begin
         if (n == 20) hold_rsp = 1'b1;
         random_request(1'b1);
         n++;
      end
      drive_request(OP_PUSH_HEAD, 8'd0, $urandom, 1'b0, '0);
      drive_request(OP_PUSH_TAIL, 8'd0, $urandom, 1'b0, '0);
      drive_request(OP_READ_INDEX, 8'd255, $urandom, 1'b0, '0);
      drive_request(OP_READ_TAIL, 8'd0, $urandom, 1'b0, '0);

      // let every response drain before the next pass
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);

      while (deque_level != 0) begin
         if (deque_level < QUIET_LEVEL) quiet = 1'b1;
         random_request(1'b0);
      end
      drive_request(OP_POP_HEAD, 8'd0, $urandom, 1'b0, '0);
      drive_request(OP_POP_TAIL, 8'd0, $urandom, 1'b0, '0);
      drive_request(OP_READ_INDEX, 8'd0, $urandom, 1'b0, '0);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses over a fill to %0d entries and a full drain;",
               results_checked, peak_level);
      $display("%0d requests were rejected as full, empty, out of range or unused.",
               rejected_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: bounded_deque_with_index_read_unit.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_ctrl.sv
sv/bdq_rsp.sv
sv/bounded_deque_with_index_read_unit.sv
bench/testbench.sv
